// ===== hw/rtl/group_reverse_reorder_assert.svh =====
// assertion macros shared by the reorder block
`ifndef GROUP_REVERSE_REORDER_ASSERT_SVH
`define GROUP_REVERSE_REORDER_ASSERT_SVH

// condition a implies condition b in the same cycle
`define GRR_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("reorder assertion failed");

// condition a implies condition b in the following cycle
`define GRR_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("reorder assertion failed");

`endif

// ===== hw/rtl/grr_pkg.sv =====
`default_nettype none

package grr_pkg;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 5;

  // default group storage depth
  localparam int GRR_MAX_GROUP = 16;

  // group size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd2;

  // memory strobes from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grr_group_mem.sv =====
`default_nettype none

module grr_group_mem import grr_pkg::*; #(
  parameter int MAX_GROUP = GRR_MAX_GROUP,
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  wire logic               clk,
  input  wire mem_ctl_t           ctl,
  input  wire logic [AW-1:0]      wr_addr,
  input  wire logic [VALUE_W-1:0] wr_data,
  input  wire logic [AW-1:0]      rd_addr,
  output logic      [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [MAX_GROUP];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds while no read is issued
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/grr_ctrl.sv =====
`default_nettype none

`include "group_reverse_reorder_assert.svh"

module grr_ctrl import grr_pkg::*; #(
  parameter int MAX_GROUP = GRR_MAX_GROUP,
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SIZE_W-1:0] group_size,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              list_end,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   burst_last,
  output logic                   list_last,
  output mem_ctl_t               mem_ctl,
  output logic      [AW-1:0]     wr_addr,
  output logic      [AW-1:0]     rd_addr
);

  localparam int KW = (AW + 1 > SIZE_W) ? AW + 1 : SIZE_W;

  logic [AW-1:0] fill_count, fill_count_next;
  logic [AW-1:0] widx;
  logic [KW-1:0] size_ext, k_eff, n_ext;
  logic          full, in_acc, emit, issue, last_rd;
  logic          busy;
  logic [AW-1:0] ptr, left;
  logic          rev, endf;

  // effective group size: zero acts as one, large values saturate
  always_comb begin
    size_ext = KW'(group_size);
    if (size_ext == '0) begin
      k_eff = KW'(1);
    end else if (size_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = size_ext;
    end
  end

  // write slot and group close decision
  always_comb begin
    if (KW'(fill_count) >= KW'(MAX_GROUP)) begin
      widx = AW'(MAX_GROUP - 1);
    end else begin
      widx = fill_count;
    end
    n_ext = KW'(widx) + KW'(1);
    full  = (n_ext >= k_eff);
  end

  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign emit     = in_acc && (full || list_end);
  assign issue    = busy && (!out_valid || !out_stall);
  assign last_rd  = (left == '0);

  // fill count update
  always_comb begin
    fill_count_next = fill_count;
    if (emit) begin
      fill_count_next = '0;
    end else if (in_acc) begin
      fill_count_next = AW'(n_ext);
    end
  end

  // memory strobes and addresses
  always_comb begin
    mem_ctl.wr_en = in_acc;
    mem_ctl.rd_en = issue;
    wr_addr       = widx;
    rd_addr       = ptr;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      if (emit) begin
        busy <= 1'b1;
      end else if (issue && last_rd) begin
        busy <= 1'b0;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // drain pointer, count and result flags
  always_ff @(posedge clk) begin
    if (emit) begin
      ptr  <= full ? widx : '0;
      left <= widx;
      rev  <= full;
      endf <= list_end;
    end else if (issue) begin
      ptr  <= rev ? (ptr - AW'(1)) : (ptr + AW'(1));
      left <= left - AW'(1);
    end
    if (issue) begin
      burst_last <= last_rd;
      list_last  <= last_rd && endf;
    end
  end

  // checks on the sequencer
  `GRR_ASSERT_NEXT(a_issue_fills_out, issue, out_valid)
  `GRR_ASSERT_NEXT(a_emit_starts_drain, emit, busy && (fill_count == '0))
  `GRR_ASSERT_NOW(a_list_last_closes_burst, out_valid && list_last, burst_last)
  `GRR_ASSERT_NEXT(a_stall_holds_flags, out_valid && out_stall && busy,
                   out_valid && $stable(burst_last) && $stable(list_last))
  `GRR_ASSERT_NEXT(a_idle_drain_holds, busy && !issue, $stable(ptr) && $stable(left))

endmodule

`default_nettype wire

// ===== hw/rtl/group_reverse_reorder.sv =====
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  group_size
// in        in         in_valid/in_stall    value, list_end
// out       out        out_valid/out_stall  out_value, burst_last, list_last
//
// an item that does not close a group does not raise in_stall
// an item that closes a group holds in_stall high while the single memory read port
// drains the group, one result per cycle while out_stall is low
// out_stall pauses the drain; the next item is taken while the last result waits
// rst is synchronous; group storage needs no clearing pass
// cfg_ready is always high, group_size resets to two

`default_nettype none

module group_reverse_reorder import grr_pkg::*; #(
  parameter int MAX_GROUP = GRR_MAX_GROUP
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic        [SIZE_W-1:0]  group_size,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                      list_end,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed      [VALUE_W-1:0] out_value,
  output logic                           burst_last,
  output logic                           list_last
);

  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic [SIZE_W-1:0]  size_reg;
  mem_ctl_t           mem_ctl;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] rd_data;

  // group size register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_reg <= group_size;
    end
  end

  // sequencer
  grr_ctrl #(.MAX_GROUP(MAX_GROUP)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .group_size (size_reg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .list_end   (list_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .burst_last (burst_last),
    .list_last  (list_last),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr)
  );

  // group storage, its read register is the output value
  grr_group_mem #(.MAX_GROUP(MAX_GROUP)) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_value = rd_data;

endmodule

`default_nettype wire

// ===== tb/group_reverse_reorder_checker.sv =====
`default_nettype none

module group_reverse_reorder_checker import grr_pkg::*; #(
  parameter int MAX_GROUP = GRR_MAX_GROUP
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_valid,
  input  wire logic                      cfg_ready,
  input  wire logic        [SIZE_W-1:0]  group_size,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                      list_end,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic signed [VALUE_W-1:0] out_value,
  input  wire logic                      burst_last,
  input  wire logic                      list_last,
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      burst_last;
    logic                      list_last;
  } reordered_t;

  // predicted results, oldest first
  reordered_t reordered_q[$];

  // shadow of the block's state
  logic        [SIZE_W-1:0]  size_reg = SIZE_RESET;
  logic signed [VALUE_W-1:0] group_mem [MAX_GROUP];
  int unsigned               held = 0;

  int fail_count = 0;
  int waiting    = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  // size in force: zero acts as one, large sizes saturate
  function automatic int unsigned group_limit(logic [SIZE_W-1:0] k);
    if (k == '0) begin
      return 1;
    end
    if (k > MAX_GROUP) begin
      return MAX_GROUP;
    end
    return int'(k);
  endfunction

  // store one value and queue the group it closes, if any
  task automatic absorb_value(logic signed [VALUE_W-1:0] v, logic ends_list);
    int unsigned limit;
    int unsigned n;
    int unsigned slot;
    bit          closes;
    reordered_t  r;
    limit = group_limit(size_reg);
    if (held >= MAX_GROUP) begin
      held = MAX_GROUP - 1;
    end
    group_mem[held] = v;
    n = held + 1;
    closes = (n >= limit);
    if (!closes && !ends_list) begin
      held = n;
    end else begin
      // a full group comes out reversed, a short tail in arrival order
      for (int unsigned i = 0; i < n; i++) begin
        slot = closes ? (n - 1 - i) : i;
        r.value      = group_mem[slot];
        r.burst_last = (i + 1 == n);
        r.list_last  = (i + 1 == n) && ends_list;
        reordered_q = {reordered_q, r};
      end
      held = 0;
    end
  endtask

  // watch the channels at each edge
  always @(posedge clk) begin
    reordered_t got;
    reordered_t want;
    if (rst) begin
      size_reg = SIZE_RESET;
      held = 0;
      reordered_q.delete();
    end else begin
      // an item taken at this edge still sees the old size
      if (in_valid && !in_stall) begin
        absorb_value(value, list_end);
      end
      if (cfg_valid && cfg_ready) begin
        size_reg = group_size;
      end
      if (out_valid && !out_stall) begin
        got.value      = out_value;
        got.burst_last = burst_last;
        got.list_last  = list_last;
        if (reordered_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item, expected none, actual value %h burst %b list %b",
                   $time, got.value, got.burst_last, got.list_last);
        end else begin
          want = reordered_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch, expected value %h burst %b list %b,",
                     $time, want.value, want.burst_last, want.list_last,
                     " actual value %h burst %b list %b",
                     got.value, got.burst_last, got.list_last);
          end
        end
      end
    end
    waiting <= reordered_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/tb_group_reverse_reorder.sv =====
`default_nettype none

module tb_group_reverse_reorder import grr_pkg::*;;

  localparam int RANDOM_ITEMS = 280;
  localparam int DRAIN_CYCLES = 20;
  localparam int STUCK_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic        [SIZE_W-1:0]  group_size = SIZE_RESET;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value      = '0;
  logic                      list_end   = 1'b0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                      burst_last;
  logic                      list_last;

  int errors;
  int pending;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int values_sent = 0;
  int stuck_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  group_reverse_reorder #(.MAX_GROUP(GRR_MAX_GROUP)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .list_end   (list_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .burst_last (burst_last),
    .list_last  (list_last)
  );

  group_reverse_reorder_checker #(.MAX_GROUP(GRR_MAX_GROUP)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .group_size (group_size),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .list_end   (list_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .burst_last (burst_last),
    .list_last  (list_last),
    .errors     (errors),
    .pending    (pending)
  );

  // random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // random value, biased toward the extremes
  function automatic logic signed [VALUE_W-1:0] next_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // random group size, mostly small, sometimes the edges
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'(GRR_MAX_GROUP);
      2: return SIZE_W'($urandom_range(GRR_MAX_GROUP + 1, 31));
      3: return SIZE_W'(1);
      default: return SIZE_W'($urandom_range(2, 8));
    endcase
  endfunction

  // offer one item and hold it until taken
  task automatic push_value(logic signed [VALUE_W-1:0] v, logic ends_list);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    list_end <= ends_list;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    values_sent++;
  endtask

  // stop sending, wait for every expected result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, to be issued only while idle; the task itself does not check for it
  task automatic set_group_size(logic [SIZE_W-1:0] k);
    cfg_valid  <= 1'b1;
    group_size <= k;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // a list of random values, closed or left open
  task automatic send_list(int len, bit closed);
    for (int i = 0; i < len; i++) begin
      push_value(next_value(), closed && (i == len - 1));
    end
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size: one reversed pair, then a single-value tail
    push_value(32'h7fff_ffff, 1'b0);
    push_value(32'h8000_0000, 1'b0);
    push_value(32'hffff_ffff, 1'b1);

    // full group landing on the list end, then a short tail in order
    settle();
    set_group_size(SIZE_W'(3));
    push_value(32'sd1, 1'b0);
    push_value(32'sd2, 1'b0);
    push_value(32'sd3, 1'b1);
    push_value(32'sd4, 1'b0);
    push_value(32'sd5, 1'b1);

    // size zero passes each value alone
    settle();
    set_group_size('0);
    push_value(32'sd6, 1'b0);
    push_value(32'sd7, 1'b1);

    // oversized setting saturates to the deepest group
    settle();
    set_group_size('1);
    for (int i = 0; i < GRR_MAX_GROUP; i++) begin
      push_value(next_value(), 1'b0);
    end

    // shrink the size while a group is partly full
    push_value(32'sd8, 1'b0);
    push_value(32'sd9, 1'b0);
    push_value(32'sd10, 1'b0);
    settle();
    set_group_size(SIZE_W'(2));
    push_value(32'sd11, 1'b0);
    push_value(32'sd12, 1'b1);

    // random lists under three idling patterns
    target = values_sent;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 24;
          recv_stall_pct = 69;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 24;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      target += RANDOM_ITEMS / 3;
      while (values_sent < target) begin
        settle();
        set_group_size(pick_size());
        repeat ($urandom_range(1, 4)) begin
          send_list($urandom_range(1, 20), $urandom_range(0, 5) != 0);
        end
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
